[design/ujet_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ujet_pkg
// Shared types, constants and byte-generation functions of the UTF-8 / JSON
// escape transcoder.
// ----------------------------------------------------------------------------
package ujet_pkg;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;
  localparam logic [7:0] CH_UPPER_U   = 8'h55;

  localparam logic [20:0] CP_ASCII_LIMIT = 21'h00080;
  localparam logic [20:0] CP_TWO_LIMIT   = 21'h00800;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h10000;

  localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;

  localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
  localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

  localparam logic [3:0] ESC_LEN = 4'd6;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_CP,
    KIND_TERM,
    KIND_ERR
  } cmd_kind_t;

  typedef struct packed {
    logic        pre_bs;
    cmd_kind_t   kind;
    logic [20:0] cp;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } front_req_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  function automatic logic [3:0] ujet_cp_len(input logic mode, input logic [20:0] cp);
    logic [3:0] len;
    if (cp < CP_ASCII_LIMIT) begin
      len = 4'd1;
    end else if (mode) begin
      len = (cp >= CP_SUPP_BASE) ? 4'd12 : ESC_LEN;
    end else if (cp < CP_TWO_LIMIT) begin
      len = 4'd2;
    end else if (cp < CP_SUPP_BASE) begin
      len = 4'd3;
    end else begin
      len = 4'd4;
    end
    return len;
  endfunction

  function automatic logic [7:0] ujet_cp_byte(input logic mode, input logic [20:0] cp,
                                               input logic [3:0] k);
    logic [20:0] d;
    logic [15:0] v;
    logic [3:0]  j;
    logic [3:0]  nib;
    logic [7:0]  res;
    d = cp - CP_SUPP_BASE;
    if (k >= ESC_LEN) begin
      j = k - ESC_LEN;
      v = {SURR_LOW_TAG, d[9:0]};
    end else begin
      j = k;
      v = (cp >= CP_SUPP_BASE) ? {SURR_HIGH_TAG, d[19:10]} : cp[15:0];
    end
    case (j)
      4'd2:    nib = v[15:12];
      4'd3:    nib = v[11:8];
      4'd4:    nib = v[7:4];
      default: nib = v[3:0];
    endcase
    res = 8'h00;
    if (cp < CP_ASCII_LIMIT) begin
      res = cp[7:0];
    end else if (mode) begin
      case (j)
        4'd0:    res = CH_BACKSLASH;
        4'd1:    res = CH_LOWER_U;
        default: res = HEX_DIGITS[nib];
      endcase
    end else if (cp < CP_TWO_LIMIT) begin
      case (k)
        4'd0:    res = {3'b110, cp[10:6]};
        default: res = {2'b10, cp[5:0]};
      endcase
    end else if (cp < CP_SUPP_BASE) begin
      case (k)
        4'd0:    res = {4'b1110, cp[15:12]};
        4'd1:    res = {2'b10, cp[11:6]};
        default: res = {2'b10, cp[5:0]};
      endcase
    end else begin
      case (k)
        4'd0:    res = {5'b11110, cp[20:18]};
        4'd1:    res = {2'b10, cp[17:12]};
        4'd2:    res = {2'b10, cp[11:6]};
        default: res = {2'b10, cp[5:0]};
      endcase
    end
    return res;
  endfunction

endpackage
`default_nettype wire

[design/ujet_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ujet_front
// Byte parser: decodes UTF-8 sequences and \u escapes, joins surrogate pairs
// and issues one output command per input byte that produces results.
// ----------------------------------------------------------------------------
module ujet_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire logic [7:0]        in_byte,
  output ujet_pkg::front_req_t   req
);
  import ujet_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CONT,
    PH_BSLASH,
    PH_HEX_A,
    PH_BS_B,
    PH_U_B,
    PH_HEX_B,
    PH_DROP
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [2:0]  rem_r, rem_nxt;
  logic [15:0] high_r, high_nxt;

  phase_t      lead_phase;
  cmd_kind_t   lead_kind;
  logic [20:0] lead_acc;
  logic [2:0]  lead_rem;

  logic        hex_ok;
  logic [3:0]  hex_nib;
  logic [15:0] hex_acc;
  logic [2:0]  rem_dec;
  logic        is_u;
  logic [20:0] pair_cp;

  always_comb begin
    hex_ok  = 1'b1;
    hex_nib = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_nib = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_nib = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_acc = {acc_r[11:0], hex_nib};
  assign rem_dec = rem_r - 3'd1;
  assign is_u    = (in_byte == CH_LOWER_U) || (in_byte == CH_UPPER_U);
  assign pair_cp = {1'b0, high_r[9:0], hex_acc[9:0]} + CP_SUPP_BASE;

  always_comb begin
    lead_phase = PH_IDLE;
    lead_kind  = KIND_NONE;
    lead_acc   = acc_r;
    lead_rem   = rem_r;
    if (in_byte == CH_NUL) begin
      lead_kind = KIND_TERM;
    end else if (in_byte[7] == 1'b0) begin
      if (in_byte == CH_BACKSLASH) begin
        lead_phase = PH_BSLASH;
      end else begin
        lead_kind = KIND_CP;
      end
    end else if (in_byte[7:5] == 3'b110) begin
      lead_acc   = {16'd0, in_byte[4:0]};
      lead_rem   = 3'd1;
      lead_phase = PH_CONT;
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_acc   = {17'd0, in_byte[3:0]};
      lead_rem   = 3'd2;
      lead_phase = PH_CONT;
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_acc   = {18'd0, in_byte[2:0]};
      lead_rem   = 3'd3;
      lead_phase = PH_CONT;
    end else begin
      lead_kind  = KIND_ERR;
      lead_phase = PH_DROP;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    high_nxt       = high_r;
    req.cmd.pre_bs = 1'b0;
    req.cmd.kind   = KIND_NONE;
    req.cmd.cp     = {13'd0, in_byte};
    case (phase_r)
      PH_CONT: begin
        if (in_byte[7:6] != 2'b10) begin
          req.cmd.kind = KIND_ERR;
          phase_nxt    = (in_byte == CH_NUL) ? PH_IDLE : PH_DROP;
        end else begin
          acc_nxt = {acc_r[14:0], in_byte[5:0]};
          rem_nxt = rem_dec;
          if (rem_dec == 3'd0) begin
            phase_nxt    = PH_IDLE;
            req.cmd.kind = KIND_CP;
            req.cmd.cp   = {acc_r[14:0], in_byte[5:0]};
          end
        end
      end
      PH_BSLASH: begin
        if (is_u) begin
          acc_nxt   = 21'd0;
          rem_nxt   = 3'd4;
          phase_nxt = PH_HEX_A;
        end else begin
          req.cmd.pre_bs = 1'b1;
          req.cmd.kind   = lead_kind;
          phase_nxt      = lead_phase;
          acc_nxt        = lead_acc;
          rem_nxt        = lead_rem;
        end
      end
      PH_HEX_A, PH_HEX_B: begin
        if (!hex_ok) begin
          req.cmd.kind = KIND_ERR;
          phase_nxt    = (in_byte == CH_NUL) ? PH_IDLE : PH_DROP;
        end else begin
          acc_nxt = {5'd0, hex_acc};
          rem_nxt = rem_dec;
          if (rem_dec == 3'd0) begin
            if (phase_r == PH_HEX_A) begin
              if (hex_acc >= SURR_HIGH_MIN && hex_acc <= SURR_HIGH_MAX) begin
                high_nxt  = hex_acc;
                phase_nxt = PH_BS_B;
              end else begin
                phase_nxt    = PH_IDLE;
                req.cmd.kind = KIND_CP;
                req.cmd.cp   = {5'd0, hex_acc};
              end
            end else begin
              phase_nxt    = PH_IDLE;
              req.cmd.kind = KIND_CP;
              if (hex_acc >= SURR_LOW_MIN && hex_acc <= SURR_LOW_MAX) begin
                req.cmd.cp = pair_cp;
              end else begin
                req.cmd.cp = {5'd0, high_r};
              end
            end
          end
        end
      end
      PH_BS_B: begin
        if (in_byte == CH_BACKSLASH) begin
          phase_nxt = PH_U_B;
        end else begin
          req.cmd.kind = KIND_ERR;
          phase_nxt    = (in_byte == CH_NUL) ? PH_IDLE : PH_DROP;
        end
      end
      PH_U_B: begin
        if (is_u) begin
          acc_nxt   = 21'd0;
          rem_nxt   = 3'd4;
          phase_nxt = PH_HEX_B;
        end else begin
          req.cmd.kind = KIND_ERR;
          phase_nxt    = (in_byte == CH_NUL) ? PH_IDLE : PH_DROP;
        end
      end
      PH_DROP: begin
        if (in_byte == CH_NUL) begin
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        req.cmd.kind = lead_kind;
        phase_nxt    = lead_phase;
        acc_nxt      = lead_acc;
        rem_nxt      = lead_rem;
      end
    endcase
    req.push = accept && (req.cmd.pre_bs || (req.cmd.kind != KIND_NONE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= 21'd0;
      rem_r   <= 3'd0;
      high_r  <= 16'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule
`default_nettype wire

[design/ujet_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ujet_queue
// Two-entry command queue between the parser and the byte generator.
// ----------------------------------------------------------------------------
module ujet_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ujet_pkg::front_req_t  req,
  input  wire logic                  pop,
  output logic                       full,
  output ujet_pkg::queue_head_t      head
);
  import ujet_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (req.push && !(pop && head.valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!req.push && pop && head.valid) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      entry_r[wr_ptr_r] <= req.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (req.push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop && head.valid) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule
`default_nettype wire

[design/ujet_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ujet_back
// Byte generator: expands each queued command into output bytes, one per
// cycle while the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ujet_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   mode,
  input  wire ujet_pkg::queue_head_t  head,
  output logic                        pop,
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output logic [7:0]                  out_byte,
  output logic                        out_end_of_text,
  output logic                        out_error_flag,
  output logic                        out_last_of_run
);
  import ujet_pkg::*;

  logic [3:0] pos_r;
  logic [3:0] body_len;
  logic [3:0] total;
  logic [3:0] k;
  logic       adv;
  logic       last;
  logic [7:0] byte_nxt;
  logic       eot_nxt;
  logic       err_nxt;

  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_eot_r;
  logic       out_err_r;
  logic       out_last_r;

  always_comb begin
    case (head.cmd.kind)
      KIND_CP:             body_len = ujet_cp_len(mode, head.cmd.cp);
      KIND_TERM, KIND_ERR: body_len = 4'd1;
      default:             body_len = 4'd0;
    endcase
  end

  assign total = body_len + {3'd0, head.cmd.pre_bs};
  assign k     = pos_r - {3'd0, head.cmd.pre_bs};
  assign adv   = head.valid && (!out_valid_r || !out_stall);
  assign last  = (pos_r == total - 4'd1);
  assign pop   = adv && last;

  always_comb begin
    byte_nxt = 8'h00;
    eot_nxt  = 1'b0;
    err_nxt  = 1'b0;
    if (head.cmd.pre_bs && (pos_r == 4'd0)) begin
      byte_nxt = CH_BACKSLASH;
    end else if (head.cmd.kind == KIND_CP) begin
      byte_nxt = ujet_cp_byte(mode, head.cmd.cp, k);
    end else begin
      eot_nxt = 1'b1;
      err_nxt = (head.cmd.kind == KIND_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
      out_eot_r  <= eot_nxt;
      out_err_r  <= err_nxt;
      out_last_r <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= 4'd0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        pos_r       <= last ? 4'd0 : pos_r + 4'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_end_of_text = out_eot_r;
  assign out_error_flag  = out_err_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

[design/utf8_json_escape_transcoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_json_escape_transcoder_core
// Converts NUL-terminated UTF-8 text with JSON \u escapes into plain UTF-8
// or into ASCII with \u escapes, one output byte per transfer.
//
//   Channel   Direction  Handshake            Payload
//   in_*      input      in_valid / in_stall  in_byte
//   out_*     output     out_valid/out_stall  out_byte, out_end_of_text,
//                                             out_error_flag, out_last_of_run
//   cfg_*     input      cfg_wr_en            cfg_wr_data (mode)
//
// The parser takes one input byte per cycle while its two-entry command queue
// has room. The byte generator emits one output byte per cycle while the
// output is not stalled, and an input byte can yield up to twelve of them.
// Reset is synchronous and active low. A stall on the output backs up the
// queue and then the input through in_stall.
// ----------------------------------------------------------------------------
module utf8_json_escape_transcoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_end_of_text,
  output logic            out_error_flag,
  output logic            out_last_of_run,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);
  import ujet_pkg::*;

  logic        mode_r;
  logic        q_full;
  logic        accept;
  logic        pop;
  front_req_t  req;
  queue_head_t head;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  ujet_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .req     (req)
  );

  ujet_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  ujet_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mode            (mode_r),
    .head            (head),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_end_of_text (out_end_of_text),
    .out_error_flag  (out_error_flag),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire
